FILE: design/fba_pkg.sv
`timescale 1ns / 1ps

package fba_pkg;

  localparam int unsigned NumFrames  = 4096;
  localparam int unsigned PageBytes  = 4096;
  localparam int unsigned WordBits   = 64;
  localparam int unsigned MapWords   = NumFrames / WordBits;

  localparam int unsigned AddrW      = 24;
  localparam int unsigned CountW     = 13;
  localparam int unsigned StatusW    = 3;
  localparam int unsigned CmdW       = 2;
  localparam int unsigned OffW       = $clog2(PageBytes);
  localparam int unsigned FrameW     = AddrW - OffW;
  localparam int unsigned BitW       = $clog2(WordBits);
  localparam int unsigned WordW      = $clog2(MapWords);

  localparam logic [CountW-1:0] TotalReset = CountW'(NumFrames);

  typedef enum logic [CmdW-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_NOMEM     = 3'd1,
    ST_UNALIGNED = 3'd2,
    ST_RANGE     = 3'd3,
    ST_FREE      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_DONE
  } state_e;

  typedef enum logic {
    REG_FRAME_TOTAL = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic                we;
    logic [WordW-1:0]    waddr;
    logic [WordBits-1:0] wdata;
    logic [WordW-1:0]    raddr;
  } ram_req_t;

  // lowest set bit of a map word
  function automatic logic [BitW-1:0] first_set(input logic [WordBits-1:0] v);
    logic [BitW-1:0] idx;
    idx = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BitW'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: design/fba_bitmap_ram.sv
`timescale 1ns / 1ps

module fba_bitmap_ram (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fba_pkg::ram_req_t            req_i,
  output logic [fba_pkg::WordBits-1:0] rdata_o
);

  logic [fba_pkg::WordBits-1:0] mem [fba_pkg::MapWords];
  logic [fba_pkg::MapWords-1:0] valid_q;
  logic [fba_pkg::WordBits-1:0] mem_rdata_q;
  logic                         rvalid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    mem_rdata_q <= mem[req_i.raddr];
  end

  // unwritten words read as all used
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      rvalid_q <= valid_q[req_i.raddr];
    end
  end

  assign rdata_o = rvalid_q ? mem_rdata_q : '1;

endmodule

FILE: design/fba_ctrl.sv
`timescale 1ns / 1ps

module fba_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [fba_pkg::CountW-1:0]   eff_total_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [fba_pkg::CmdW-1:0]     in_cmd_i,
  input  logic [fba_pkg::AddrW-1:0]    in_addr_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [fba_pkg::StatusW-1:0]  out_status_o,
  output logic [fba_pkg::AddrW-1:0]    out_addr_o,
  output logic [fba_pkg::CountW-1:0]   out_free_o,
  output fba_pkg::ram_req_t            ram_req_o,
  input  logic [fba_pkg::WordBits-1:0] ram_rdata_i
);

  localparam int unsigned OffW   = fba_pkg::OffW;
  localparam int unsigned BitW   = fba_pkg::BitW;
  localparam int unsigned WordW  = fba_pkg::WordW;
  localparam int unsigned WB     = fba_pkg::WordBits;
  localparam int unsigned CountW = fba_pkg::CountW;

  fba_pkg::state_e state_q, state_d;

  fba_pkg::cmd_e               cmd_q;
  logic [fba_pkg::AddrW-1:0]   addr_q;
  logic [WordW-1:0]            word_q, word_d;
  logic [CountW-1:0]           count_q, count_d;
  fba_pkg::status_e            res_status_q, res_status_d;
  logic [fba_pkg::AddrW-1:0]   res_addr_q, res_addr_d;
  logic                        out_valid_q;
  logic [fba_pkg::StatusW-1:0] out_status_q;
  logic [fba_pkg::AddrW-1:0]   out_addr_q;
  logic [CountW-1:0]           out_free_q;

  logic                        accept;
  logic                        out_load;

  // allocate scan
  logic [CountW-BitW-1:0]      tot_word;
  logic [BitW-1:0]             tot_bit;
  logic [CountW-BitW-1:0]      cur_word;
  logic [WB-1:0]               lim_mask;
  logic [WB-1:0]               cand;
  logic                        found;
  logic [BitW-1:0]             found_bit;
  logic                        last_word;

  // free / release
  logic [BitW-1:0]             upd_bit;
  logic                        unaligned;
  logic                        out_range;
  logic                        bit_used;

  assign tot_word  = eff_total_i[CountW-1:BitW];
  assign tot_bit   = eff_total_i[BitW-1:0];
  assign cur_word  = (CountW - BitW)'(word_q);

  always_comb begin
    if (cur_word < tot_word) begin
      lim_mask = '1;
    end else if (cur_word == tot_word) begin
      lim_mask = (WB'(1) << tot_bit) - WB'(1);
    end else begin
      lim_mask = '0;
    end
    cand = ~ram_rdata_i & lim_mask;
    if (word_q == '0) begin
      cand[0] = 1'b0;
    end
  end

  assign found     = |cand;
  assign found_bit = fba_pkg::first_set(cand);
  assign last_word = {(cur_word + 1'b1), {BitW{1'b0}}} >= eff_total_i;

  assign upd_bit   = addr_q[OffW+BitW-1:OffW];
  assign unaligned = addr_q[OffW-1:0] != '0;
  assign out_range = {1'b0, addr_q[fba_pkg::AddrW-1:OffW]} >= eff_total_i;
  assign bit_used  = ram_rdata_i[upd_bit];

  assign accept   = in_valid_i && in_ready_o;
  assign out_load = (state_q == fba_pkg::S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fba_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = (fba_pkg::cmd_e'(in_cmd_i) == fba_pkg::CMD_ALLOC) ?
                    fba_pkg::S_SCAN : fba_pkg::S_UPDATE;
        end
      end
      fba_pkg::S_SCAN: begin
        if (found || last_word) begin
          state_d = fba_pkg::S_DONE;
        end
      end
      fba_pkg::S_UPDATE: state_d = fba_pkg::S_DONE;
      fba_pkg::S_DONE: begin
        if (out_load) begin
          state_d = fba_pkg::S_IDLE;
        end
      end
      default: state_d = fba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    word_d          = word_q;
    count_d         = count_q;
    res_status_d    = res_status_q;
    res_addr_d      = res_addr_q;
    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = word_q;
    ram_req_o.wdata = ram_rdata_i;
    unique case (state_q)
      fba_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        word_d     = (fba_pkg::cmd_e'(in_cmd_i) == fba_pkg::CMD_ALLOC) ?
                     '0 : in_addr_i[fba_pkg::AddrW-1:OffW+BitW];
      end
      fba_pkg::S_SCAN: begin
        res_addr_d = '0;
        if (found) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.wdata = ram_rdata_i | (WB'(1) << found_bit);
          count_d         = count_q - 1'b1;
          res_status_d    = fba_pkg::ST_OK;
          res_addr_d      = {word_q, found_bit, {OffW{1'b0}}};
        end else if (last_word) begin
          res_status_d = fba_pkg::ST_NOMEM;
        end else begin
          word_d = word_q + 1'b1;
        end
      end
      fba_pkg::S_UPDATE: begin
        res_addr_d   = '0;
        res_status_d = fba_pkg::ST_OK;
        if (cmd_q == fba_pkg::CMD_FREE || cmd_q == fba_pkg::CMD_RELEASE) begin
          if (unaligned) begin
            res_status_d = fba_pkg::ST_UNALIGNED;
          end else if (out_range) begin
            res_status_d = fba_pkg::ST_RANGE;
          end else if (bit_used) begin
            ram_req_o.we    = 1'b1;
            ram_req_o.wdata = ram_rdata_i & ~(WB'(1) << upd_bit);
            count_d         = count_q + 1'b1;
          end else if (cmd_q == fba_pkg::CMD_FREE) begin
            res_status_d = fba_pkg::ST_FREE;
          end
        end
      end
      fba_pkg::S_DONE: ;
      default: ;
    endcase
    ram_req_o.raddr = word_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fba_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q       <= word_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    if (accept) begin
      cmd_q  <= fba_pkg::cmd_e'(in_cmd_i);
      addr_q <= in_addr_i;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
      out_free_q   <= count_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_addr_o   = out_addr_q;
  assign out_free_o   = out_free_q;

endmodule

FILE: design/frame_bitmap_allocator_top.sv
// Free, release and no-op pass through S_UPDATE to S_DONE; allocate scans map words in S_SCAN,
// 1 to 64 of them (one 64-bit word per cycle), then goes to S_DONE.
// One command at a time; the next is taken once the result is registered into the output
// register, which waits while a previous result is still held back by m_axis_tready.
// Reset: all frames read as used at once (per-word valid bits), free count 0,
// frame_total 4096; no clearing pass.
`timescale 1ns / 1ps

module frame_bitmap_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // address[23:0]
  input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // status[2:0], frame_address[26:3], free_frames[39:27]
);

  localparam int unsigned CountW = fba_pkg::CountW;

  logic [CountW-1:0]            frame_total_q;
  logic [CountW-1:0]            eff_total;
  fba_pkg::reg_idx_e            reg_idx;
  fba_pkg::ram_req_t            ram_req;
  logic [fba_pkg::WordBits-1:0] ram_rdata;
  logic [fba_pkg::StatusW-1:0]  out_status;
  logic [fba_pkg::AddrW-1:0]    out_addr;
  logic [CountW-1:0]            out_free;
  logic                         cfg_sel;

  assign pready  = 1'b1;
  assign reg_idx = fba_pkg::reg_idx_e'(paddr[2]);
  assign cfg_sel = (paddr[2] == 1'b0) && (paddr[1:0] == 2'b00);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_total_q <= fba_pkg::TotalReset;
    end else if (psel && penable && pwrite && reg_idx == fba_pkg::REG_FRAME_TOTAL) begin
      frame_total_q <= pwdata[CountW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_sel) begin
      prdata = {{(32 - CountW){1'b0}}, frame_total_q};
    end
  end

  assign eff_total = (frame_total_q > fba_pkg::TotalReset) ? fba_pkg::TotalReset
                                                           : frame_total_q;

  fba_bitmap_ram u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  fba_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .eff_total_i  (eff_total),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_cmd_i     (s_axis_tuser),
    .in_addr_i    (s_axis_tdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_addr_o   (out_addr),
    .out_free_o   (out_free),
    .ram_req_o    (ram_req),
    .ram_rdata_i  (ram_rdata)
  );

  assign m_axis_tdata = {out_free, out_addr, out_status};

endmodule

FILE: tb/sv/tb_frame_bitmap_allocator_top.sv
`timescale 1ns / 1ps

module tb_frame_bitmap_allocator_top;
  import fba_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned PhaseWords = 60;
  localparam int unsigned NumPhases = 8;

  typedef struct packed {
    status_e           st;
    logic [AddrW-1:0]  fa;
    logic [CountW-1:0] cnt;
  } alloc_result_t;

  // config rows carry the new frame_total in addr
  typedef struct packed {
    bit                is_cfg;
    cmd_e              cmd;
    logic [AddrW-1:0]  addr;
    bit                known;
    alloc_result_t     res;
  } dir_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata;  // address[23:0]
  logic [1:0]        s_axis_tuser;  // cmd[1:0]
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [39:0]       m_axis_tdata;  // status[2:0], frame_address[26:3], free_frames[39:27]

  bit                used_map [NumFrames];
  logic [CountW-1:0] free_cnt;
  logic [CountW-1:0] frame_total;

  alloc_result_t     pending_results [$];
  logic [AddrW-1:0]  held_frames [$];
  alloc_result_t     want;
  dir_row_t          dir_tab [26];

  bit                calm;
  int unsigned       err_cnt;
  int unsigned       cycles;
  int unsigned       stall_left;
  int unsigned       n_words;
  int unsigned       n_results;
  int unsigned       n_cfg;
  int unsigned       st_seen [8];

  frame_bitmap_allocator_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 8);
  endfunction

  function automatic int unsigned usable_frames();
    return (frame_total > NumFrames) ? NumFrames : int'(frame_total);
  endfunction

  function automatic alloc_result_t predict_alloc(input cmd_e c, input logic [AddrW-1:0] a);
    alloc_result_t r;
    int unsigned   lim;
    int unsigned   fr;
    status_e       chk;
    r.st = ST_OK;
    r.fa = '0;
    lim = usable_frames();
    fr = a / PageBytes;
    if (a % PageBytes != 0) begin
      chk = ST_UNALIGNED;
    end else if (a >= lim * PageBytes) begin
      chk = ST_RANGE;
    end else begin
      chk = ST_OK;
    end
    case (c)
      CMD_ALLOC: begin
        r.st = ST_NOMEM;
        for (int i = 1; i < lim; i++) begin
          if (!used_map[i]) begin
            used_map[i] = 1'b1;
            free_cnt--;
            r.fa = AddrW'(i * PageBytes);
            r.st = ST_OK;
            break;
          end
        end
      end
      CMD_FREE: begin
        r.st = chk;
        if (chk == ST_OK) begin
          if (!used_map[fr]) begin
            r.st = ST_FREE;
          end else begin
            used_map[fr] = 1'b0;
            free_cnt++;
          end
        end
      end
      CMD_RELEASE: begin
        r.st = chk;
        if (chk == ST_OK && used_map[fr]) begin
          used_map[fr] = 1'b0;
          free_cnt++;
        end
      end
      default: begin
      end
    endcase
    r.cnt = free_cnt;
    return r;
  endfunction

  task automatic send_cmd(input cmd_e c, input logic [AddrW-1:0] a, input bit known,
                          input alloc_result_t typed);
    alloc_result_t r;
    int unsigned   gap;
    r = predict_alloc(c, a);
    if (c == CMD_ALLOC && r.st == ST_OK) begin
      held_frames.push_back(r.fa);
    end
    pending_results.push_back(known ? typed : r);
    n_words++;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= a;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
  endtask

  task automatic set_frame_total(input logic [CountW-1:0] v);
    drain();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(int'(REG_FRAME_TOTAL) * 4);
    pwdata  <= 32'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    frame_total = v;
    n_cfg++;
    @(negedge clk_i);
    psel    <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== 32'(v)) begin
      $error("frame_total readback: expected %0d, got %0d", v, prdata);
      err_cnt++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [AddrW-1:0] pick_frame_addr();
    int unsigned top;
    top = usable_frames() + 4;
    if (top > NumFrames - 1) begin
      top = NumFrames - 1;
    end
    if ($urandom_range(9) < 7) begin
      return AddrW'($urandom_range(top) * PageBytes);
    end
    return AddrW'($urandom_range(NumFrames - 1) * PageBytes);
  endfunction

  task automatic random_phase(input int unsigned count);
    int unsigned      r;
    int unsigned      k;
    cmd_e             c;
    logic [AddrW-1:0] a;
    for (int n = 0; n < count; n++) begin
      r = (n < 8) ? 70 : $urandom_range(99);
      if (r < 35) begin
        c = CMD_ALLOC;
        a = AddrW'($urandom());
      end else if (r < 60) begin
        c = CMD_FREE;
        if (held_frames.size() != 0) begin
          k = $urandom_range(held_frames.size() - 1);
          a = held_frames[k];
          held_frames.delete(k);
        end else begin
          a = pick_frame_addr();
        end
      end else if (r < 80) begin
        c = CMD_RELEASE;
        a = pick_frame_addr();
      end else begin
        c = cmd_e'($urandom_range(3));
        case ($urandom_range(2))
          0: a = AddrW'($urandom());
          1: a = pick_frame_addr();
          default: a = pick_frame_addr() | AddrW'($urandom_range(PageBytes - 1, 1));
        endcase
      end
      send_cmd(c, a, 1'b0, '0);
    end
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && $urandom_range(3) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      st_seen[m_axis_tdata[2:0]]++;
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending: %h", m_axis_tdata);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[2:0] !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, m_axis_tdata[2:0]);
          err_cnt++;
        end
        if (m_axis_tdata[26:3] !== want.fa) begin
          $error("frame_address: expected %h, got %h", want.fa, m_axis_tdata[26:3]);
          err_cnt++;
        end
        if (m_axis_tdata[39:27] !== want.cnt) begin
          $error("free_frames: expected %0d, got %0d", want.cnt, m_axis_tdata[39:27]);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("frame_bitmap_allocator_top verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned totals [NumPhases];
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_NOP;
    foreach (used_map[i]) begin
      used_map[i] = 1'b1;
    end
    free_cnt    = '0;
    frame_total = TotalReset;
    calm        = 1'b0;

    dir_tab = '{
      '{1'b0, CMD_ALLOC,   24'h000000, 1'b1, '{ST_NOMEM,     24'h000000, 13'd0}},
      '{1'b0, CMD_FREE,    24'h001000, 1'b1, '{ST_OK,        24'h000000, 13'd1}},
      '{1'b0, CMD_FREE,    24'h001000, 1'b1, '{ST_FREE,      24'h000000, 13'd1}},
      '{1'b0, CMD_FREE,    24'h001001, 1'b1, '{ST_UNALIGNED, 24'h000000, 13'd1}},
      '{1'b0, CMD_RELEASE, 24'h000800, 1'b1, '{ST_UNALIGNED, 24'h000000, 13'd1}},
      '{1'b0, CMD_RELEASE, 24'hFFF000, 1'b1, '{ST_OK,        24'h000000, 13'd2}},
      '{1'b0, CMD_RELEASE, 24'hFFF000, 1'b1, '{ST_OK,        24'h000000, 13'd2}},
      '{1'b0, CMD_RELEASE, 24'h000000, 1'b1, '{ST_OK,        24'h000000, 13'd3}},
      '{1'b0, CMD_ALLOC,   24'hFFFFFF, 1'b1, '{ST_OK,        24'h001000, 13'd2}},
      '{1'b0, CMD_ALLOC,   24'h000000, 1'b1, '{ST_OK,        24'hFFF000, 13'd1}},
      '{1'b0, CMD_ALLOC,   24'h000000, 1'b1, '{ST_NOMEM,     24'h000000, 13'd1}},
      '{1'b0, CMD_NOP,     24'hFFFFFF, 1'b1, '{ST_OK,        24'h000000, 13'd1}},
      '{1'b0, CMD_FREE,    24'h000000, 1'b1, '{ST_FREE,      24'h000000, 13'd1}},
      '{1'b0, CMD_FREE,    24'hFFFFFF, 1'b1, '{ST_UNALIGNED, 24'h000000, 13'd1}},
      '{1'b0, CMD_FREE,    24'hFFF000, 1'b1, '{ST_OK,        24'h000000, 13'd2}},
      '{1'b1, CMD_NOP,     24'd16,     1'b0, '0},
      '{1'b0, CMD_FREE,    24'h010000, 1'b1, '{ST_RANGE,     24'h000000, 13'd2}},
      '{1'b0, CMD_RELEASE, 24'hFFF000, 1'b1, '{ST_RANGE,     24'h000000, 13'd2}},
      '{1'b0, CMD_ALLOC,   24'h000000, 1'b1, '{ST_NOMEM,     24'h000000, 13'd2}},
      '{1'b0, CMD_RELEASE, 24'h00F000, 1'b0, '0},
      '{1'b0, CMD_ALLOC,   24'h000000, 1'b0, '0},
      '{1'b1, CMD_NOP,     24'd0,      1'b0, '0},
      '{1'b0, CMD_RELEASE, 24'h000000, 1'b1, '{ST_RANGE,     24'h000000, 13'd2}},
      '{1'b0, CMD_ALLOC,   24'h000000, 1'b1, '{ST_NOMEM,     24'h000000, 13'd2}},
      '{1'b1, CMD_NOP,     24'd8191,   1'b0, '0},
      '{1'b0, CMD_ALLOC,   24'h000000, 1'b1, '{ST_OK,        24'hFFF000, 13'd1}}
    };
    totals = '{4096, 48, 1, 8191, 0, $urandom_range(600, 2), 4097, 4096};

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        set_frame_total(CountW'(dir_tab[i].addr));
      end else begin
        send_cmd(dir_tab[i].cmd, dir_tab[i].addr, dir_tab[i].known, dir_tab[i].res);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      set_frame_total(CountW'(totals[p]));
      calm = (p == 3);
      random_phase(PhaseWords);
    end

    drain();
    repeat (80) @(posedge clk_i);
    $display("%0d command words, %0d results, %0d frame_total writes (0, 1, 16, 4096, 8191 incl.)",
             n_words, n_results, n_cfg);
    $display("results by status: ok %0d, no memory %0d, unaligned %0d, range %0d, freed %0d",
             st_seen[ST_OK], st_seen[ST_NOMEM], st_seen[ST_UNALIGNED], st_seen[ST_RANGE],
             st_seen[ST_FREE]);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("frame_bitmap_allocator_top verification clean");
    end else begin
      $display("frame_bitmap_allocator_top verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/fba_pkg.sv
design/fba_bitmap_ram.sv
design/fba_ctrl.sv
design/frame_bitmap_allocator_top.sv
tb/sv/tb_frame_bitmap_allocator_top.sv
